[src/hst_pkg.sv]
// ----------------------------------------------------------------------------
// Hashed symbol table package
// Shared widths, codes, result record and control records of the block.
// ----------------------------------------------------------------------------
package hst_pkg;

  // Fixed field widths of the stream items.
  localparam int CHAR_W      = 7;
  localparam int NEW_VALUE_W = 16;
  localparam int VALUE_OUT_W = 16;
  localparam int SLOT_OUT_W  = 8;
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 3;
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 32;

  // Character count saturates at the largest value this width holds.
  localparam int CNT_W       = 6;

  // Hash accumulator width.
  localparam int HASH_W      = 32;

  // Parameter defaults.
  localparam int DEF_TABLE_SLOTS    = 256;
  localparam int DEF_MAX_NAME_CHARS = 31;
  localparam int DEF_VALUE_BITS     = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_SET    = 2'd2,
    CMD_GET    = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK          = 3'd0,
    STAT_EXISTS      = 3'd1,
    STAT_NOT_FOUND   = 3'd2,
    STAT_COLLISION   = 3'd3,
    STAT_ALREADY_SET = 3'd4,
    STAT_TOO_LONG    = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH2,
    ST_MOD_GO,
    ST_MOD,
    ST_SLOT_RD,
    ST_SLOT_CHK,
    ST_CMP_RD,
    ST_CMP_CHK,
    ST_NAME_WR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic step;
  } hash_ctl_t;

  typedef struct packed {
    logic [SLOT_OUT_W-1:0]  slot;
    logic                   value_valid;
    logic [VALUE_OUT_W-1:0] value_out;
    logic                   found;
    status_t                status;
  } result_t;

endpackage

[src/hst_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module hst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/hst_hash_unit.sv]
// ----------------------------------------------------------------------------
// Hash step unit
// Holds the hash and applies h = (h + c) * c once per step; two steps per
// character give the full update.
// ----------------------------------------------------------------------------
module hst_hash_unit
  import hst_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  hash_ctl_t         ctl,
  input  logic [CHAR_W-1:0] c,
  output logic [HASH_W-1:0] hash
);

  logic [HASH_W-1:0] c_ext;
  logic [HASH_W-1:0] product;

  assign c_ext   = HASH_W'(c);
  assign product = (hash + c_ext) * c_ext;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      hash <= '0;
    end else if (ctl.step) begin
      hash <= product;
    end
  end

endmodule

[src/hst_mod_unit.sv]
// ----------------------------------------------------------------------------
// Slot remainder unit
// Reduces the hash modulo the slot count with a scaled-reciprocal multiply,
// a back-multiply and one compare and subtract; a power-of-two slot count is
// a plain mask.
// ----------------------------------------------------------------------------
module hst_mod_unit
  import hst_pkg::*;
#(
  parameter int TABLE_SLOTS = DEF_TABLE_SLOTS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [HASH_W-1:0]              dividend,
  output logic                           done,
  output logic [$clog2(TABLE_SLOTS)-1:0] rem
);

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int RW     = SLOT_W + 1;
  localparam bit POW2   = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
  // 2^32 / TABLE_SLOTS rounded down. The quotient estimate it gives is low by
  // at most one, so the first remainder stays below twice the slot count.
  localparam longint unsigned   RECIP_L = (64'd1 << HASH_W) / TABLE_SLOTS;
  localparam logic [HASH_W-1:0] RECIP   = HASH_W'(RECIP_L);
  localparam logic [RW-1:0]     MODULUS = RW'(TABLE_SLOTS);

  logic              est_busy;
  logic              fix_busy;
  logic [RW-1:0]     hold;
  logic [RW-1:0]     quo;
  logic [RW-1:0]     quo_next;
  logic [RW-1:0]     rough;
  logic [SLOT_W-1:0] rem_r;

  // The remainder fits in RW bits, so only the low bits of the quotient and
  // of the dividend take part in the back-multiply.
  assign quo_next = RW'(({{HASH_W{1'b0}}, dividend} * {{HASH_W{1'b0}}, RECIP}) >> HASH_W);
  assign rem      = rem_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      est_busy <= 1'b0;
      fix_busy <= 1'b0;
      done     <= 1'b0;
    end else begin
      est_busy <= start && !POW2;
      fix_busy <= est_busy;
      done     <= (start && POW2) || fix_busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hold <= dividend[RW-1:0];
      quo  <= quo_next;
      if (POW2) begin
        rem_r <= dividend[SLOT_W-1:0];
      end
    end
    if (est_busy) begin
      rough <= hold - quo * MODULUS;
    end
    if (fix_busy) begin
      rem_r <= (rough >= MODULUS) ? SLOT_W'(rough - MODULUS) : rough[SLOT_W-1:0];
    end
  end

endmodule

[src/hashed_symbol_table.sv]
// ----------------------------------------------------------------------------
// Hashed symbol table
// Direct-mapped symbol table keyed by a streamed name, one symbol per slot.
// ----------------------------------------------------------------------------
// Usage: a name enters on the s_ channel one character per item; the item
// with s_tlast high carries the command in s_tuser and, for a set, the value.
// Every last item yields exactly one result item on the m_ channel; other
// items yield none. The hash is updated by a single add-and-multiply unit
// that is applied twice per character, and the block is ready again right
// after. On the last character the slot is found by a remainder unit that
// multiplies by a scaled reciprocal and corrects once, or masks when the slot
// count is a power of two; then the slot record is read, and the name is
// compared with the stored one character by character, or written into the
// character memory on an insert. A miss on a command other than insert, a
// name of another length or an overlong name skips the character phase. The
// time is set by the remainder unit and by the character RAM, whose read and
// write ports share one address.
// After reset the slot memory is swept to empty, one slot per cycle, and
// s_tready stays low meanwhile. A result waits in an output register while
// m_tready is low; the block keeps taking the characters of the next name
// and stalls only when its next result is due.
// ----------------------------------------------------------------------------
module hashed_symbol_table
  import hst_pkg::*;
#(
  parameter int TABLE_SLOTS    = DEF_TABLE_SLOTS,
  parameter int MAX_NAME_CHARS = DEF_MAX_NAME_CHARS,
  parameter int VALUE_BITS     = DEF_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // name_char[6:0], new_value[22:7], zero[23]
  input  logic                  s_tlast,   // last character of the name
  input  logic [CMD_W-1:0]      s_tuser,   // command[1:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // status[2:0], found[3], value_out[19:4],
                                           // value_valid[20], slot[28:21], zero[31:29]
);

  localparam int SLOT_W  = $clog2(TABLE_SLOTS);
  localparam int NB_W    = (MAX_NAME_CHARS > 1) ? $clog2(MAX_NAME_CHARS) : 1;
  localparam int CDEPTH  = TABLE_SLOTS * MAX_NAME_CHARS;
  localparam int CA_W    = $clog2(CDEPTH);
  // Slot record: value, stored length, value-known flag, occupied flag.
  localparam int LEN_LO  = VALUE_BITS;
  localparam int VK_BIT  = VALUE_BITS + CNT_W;
  localparam int OCC_BIT = VALUE_BITS + CNT_W + 1;
  localparam int REC_W   = VALUE_BITS + CNT_W + 2;

  state_t state, state_next;

  // Item fields held while the item is worked on.
  logic [CHAR_W-1:0]     c_reg;
  cmd_t                  cmd_reg;
  logic                  last_reg;
  logic [VALUE_BITS-1:0] nv_reg;

  logic [CNT_W-1:0]  count;
  logic [CHAR_W-1:0] name_buf [MAX_NAME_CHARS];
  logic [CNT_W-1:0]  idx;
  logic [SLOT_W-1:0] clr_idx;
  logic [CA_W-1:0]   char_base;

  result_t res;
  result_t out;
  logic    out_valid;

  // Shared units.
  hash_ctl_t         hctl;
  logic [CHAR_W-1:0] hash_c;
  logic [HASH_W-1:0] hash;
  logic              mod_start;
  logic              mod_done;
  logic [SLOT_W-1:0] slot;

  // Memory ports.
  logic              slot_we;
  logic [SLOT_W-1:0] slot_waddr;
  logic [REC_W-1:0]  slot_wdata;
  logic [REC_W-1:0]  slot_rdata;
  logic              char_we;
  logic [CA_W-1:0]   char_addr;
  logic [CHAR_W-1:0] char_rdata;

  logic                  accept;
  logic                  too_long;
  logic                  rec_occ;
  logic                  rec_vk;
  logic [CNT_W-1:0]      rec_len;
  logic [VALUE_BITS-1:0] rec_val;
  logic [CHAR_W-1:0]     buf_char;
  logic                  last_char;

  assign accept    = s_tvalid && s_tready;
  assign too_long  = count > CNT_W'(MAX_NAME_CHARS);
  assign rec_occ   = slot_rdata[OCC_BIT];
  assign rec_vk    = slot_rdata[VK_BIT];
  assign rec_len   = slot_rdata[VK_BIT-1:LEN_LO];
  assign rec_val   = slot_rdata[VALUE_BITS-1:0];
  assign buf_char  = name_buf[idx[NB_W-1:0]];
  assign last_char = (idx + 1'b1) == count;
  assign char_addr = char_base + CA_W'(idx);
  assign hash_c    = (state == ST_IDLE) ? s_tdata[CHAR_W-1:0] : c_reg;

  hst_hash_unit u_hash (
    .clk  (clk),
    .rst  (rst),
    .ctl  (hctl),
    .c    (hash_c),
    .hash (hash)
  );

  hst_mod_unit #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (hash),
    .done     (mod_done),
    .rem      (slot)
  );

  hst_ram #(
    .WIDTH (REC_W),
    .DEPTH (TABLE_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot),
    .rdata (slot_rdata)
  );

  hst_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CDEPTH)
  ) u_char_ram (
    .clk   (clk),
    .we    (char_we),
    .waddr (char_addr),
    .wdata (buf_char),
    .raddr (char_addr),
    .rdata (char_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state, unit control and memory writes.
  always_comb begin
    state_next = state;
    hctl       = '0;
    mod_start  = 1'b0;
    s_tready   = 1'b0;
    slot_we    = 1'b0;
    slot_waddr = slot;
    slot_wdata = '0;
    char_we    = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_idx;
        if (clr_idx == SLOT_W'(TABLE_SLOTS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          hctl.step  = 1'b1;
          state_next = ST_HASH2;
        end
      end
      ST_HASH2: begin
        hctl.step  = 1'b1;
        state_next = last_reg ? ST_MOD_GO : ST_IDLE;
      end
      ST_MOD_GO: begin
        mod_start  = 1'b1;
        state_next = ST_MOD;
      end
      ST_MOD: begin
        if (mod_done) begin
          state_next = ST_SLOT_RD;
        end
      end
      ST_SLOT_RD: begin
        state_next = ST_SLOT_CHK;
      end
      ST_SLOT_CHK: begin
        if (too_long) begin
          state_next = ST_DONE;
        end else if (!rec_occ) begin
          if (cmd_reg == CMD_INSERT) begin
            slot_we    = 1'b1;
            slot_wdata = {1'b1, 1'b0, count, VALUE_BITS'(0)};
            state_next = ST_NAME_WR;
          end else begin
            state_next = ST_DONE;
          end
        end else if (rec_len != count) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_CMP_RD;
        end
      end
      ST_CMP_RD: begin
        state_next = ST_CMP_CHK;
      end
      ST_CMP_CHK: begin
        if (char_rdata != buf_char) begin
          state_next = ST_DONE;
        end else if (last_char) begin
          if (cmd_reg == CMD_SET && !rec_vk) begin
            slot_we    = 1'b1;
            slot_wdata = {1'b1, 1'b1, rec_len, nv_reg};
          end
          state_next = ST_DONE;
        end else begin
          state_next = ST_CMP_RD;
        end
      end
      ST_NAME_WR: begin
        char_we = 1'b1;
        if (last_char) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || m_tready) begin
          hctl.clear = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control counters and the output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (accept && count != {CNT_W{1'b1}}) begin
        count <= count + 1'b1;
      end
      if (state == ST_DONE && (!out_valid || m_tready)) begin
        count     <= '0;
        out_valid <= 1'b1;
      end
    end
  end

  // Item fields, name buffer, compare index and result record.
  always_ff @(posedge clk) begin
    if (accept) begin
      c_reg    <= s_tdata[CHAR_W-1:0];
      cmd_reg  <= cmd_t'(s_tuser);
      last_reg <= s_tlast;
      nv_reg   <= VALUE_BITS'(HASH_W'(s_tdata[CHAR_W +: NEW_VALUE_W]));
      if (count < CNT_W'(MAX_NAME_CHARS)) begin
        name_buf[count[NB_W-1:0]] <= s_tdata[CHAR_W-1:0];
      end
    end
    unique case (state)
      ST_SLOT_RD: begin
        char_base <= CA_W'(slot * MAX_NAME_CHARS);
      end
      ST_SLOT_CHK: begin
        idx             <= '0;
        res.slot        <= SLOT_OUT_W'(HASH_W'(slot));
        res.found       <= 1'b0;
        res.value_out   <= '0;
        res.value_valid <= 1'b0;
        if (too_long) begin
          res.status <= STAT_TOO_LONG;
        end else if (!rec_occ) begin
          res.status <= (cmd_reg == CMD_INSERT) ? STAT_OK : STAT_NOT_FOUND;
        end else begin
          res.status <= STAT_COLLISION;
        end
      end
      ST_CMP_CHK: begin
        idx <= idx + 1'b1;
        if (char_rdata == buf_char && last_char) begin
          res.found <= 1'b1;
          if (cmd_reg == CMD_SET && !rec_vk) begin
            res.status      <= STAT_OK;
            res.value_valid <= 1'b1;
            res.value_out   <= VALUE_OUT_W'(HASH_W'(nv_reg));
          end else begin
            if (cmd_reg == CMD_INSERT) begin
              res.status <= STAT_EXISTS;
            end else if (cmd_reg == CMD_SET) begin
              res.status <= STAT_ALREADY_SET;
            end else begin
              res.status <= STAT_OK;
            end
            res.value_valid <= rec_vk;
            res.value_out   <= rec_vk ? VALUE_OUT_W'(HASH_W'(rec_val)) : '0;
          end
        end
      end
      ST_NAME_WR: begin
        idx <= idx + 1'b1;
      end
      ST_DONE: begin
        if (!out_valid || m_tready) begin
          out <= res;
        end
      end
      default: begin
      end
    endcase
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out.slot, out.value_valid, out.value_out, out.found,
                     out.status};

  // A last character always leads into the long slot phase, so the block
  // cannot take another item on the cycle after it.
  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    accept && s_tlast |=> !s_tready)
    else $error("input taken right after a last character");

  // An overlong name never reports a symbol.
  a_too_long_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out.status == STAT_TOO_LONG |-> !out.found && !out.value_valid)
    else $error("too-long result carries symbol fields");

  // A matched symbol is never reported as missing or colliding.
  a_found_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && out.found |->
      out.status != STAT_NOT_FOUND && out.status != STAT_COLLISION &&
      out.status != STAT_TOO_LONG)
    else $error("found with a failing status");

  // Without a match there is no value to report.
  a_value_needs_match: assert property (@(posedge clk) disable iff (rst)
    out_valid && out.value_valid |-> out.found)
    else $error("value reported without a matched symbol");

endmodule
